### rtl/fractal_escape_time_iterator_defines.svh
// Assertion helpers for the fractal iterator
`ifndef FRACTAL_ESCAPE_TIME_ITERATOR_DEFINES_SVH
`define FRACTAL_ESCAPE_TIME_ITERATOR_DEFINES_SVH

`define FETI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define FETI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/feti_pkg.sv
`default_nettype none
package feti_pkg;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned FracBits  = 28;
  localparam int unsigned CountBits = 16;
  localparam int unsigned AccBits   = 2 * WordBits + 1;
  localparam int unsigned PowerMin  = 3;
  localparam int unsigned PowerMax  = 6;

  typedef logic signed [WordBits-1:0] word_t;
  typedef logic signed [AccBits-1:0]  acc_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CHK  = 4'b0010,
    S_MUL  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_POWER = 2'd1,
    REG_MAXIT = 2'd2,
    REG_THR   = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    MODE_SQUARE = 2'd0,
    MODE_SHIP   = 2'd1,
    MODE_MULTI  = 2'd2,
    MODE_HYBRID = 2'd3
  } mode_e;

  localparam word_t WordMax = {1'b0, {(WordBits-1){1'b1}}};
  localparam word_t WordMin = {1'b1, {(WordBits-1){1'b0}}};

  function automatic word_t sat_abs(input word_t v);
    word_t r;
    r = v;
    if (v == WordMin) r = WordMax;
    else if (v[WordBits-1]) r = -v;
    return r;
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [WordBits:0] s;
    word_t r;
    s = {a[WordBits-1], a} + {b[WordBits-1], b};
    r = s[WordBits-1:0];
    if (s[WordBits] != s[WordBits-1]) r = s[WordBits] ? WordMin : WordMax;
    return r;
  endfunction

  // floor shift by the fraction bits, then clamp to a word
  function automatic word_t narrow(input acc_t a);
    logic signed [AccBits-FracBits-1:0] t;
    word_t r;
    t = a[AccBits-1:FracBits];
    r = t[WordBits-1:0];
    if (t[AccBits-FracBits-1:WordBits-1] != {(AccBits-FracBits-WordBits+1){1'b0}} &&
        t[AccBits-FracBits-1:WordBits-1] != {(AccBits-FracBits-WordBits+1){1'b1}})
      r = t[AccBits-FracBits-1] ? WordMin : WordMax;
    return r;
  endfunction
endpackage
`default_nettype wire

### rtl/fractal_escape_time_iterator.sv
`default_nettype none
`include "fractal_escape_time_iterator_defines.svh"
// Escape-time iterator: one request at a time on a single shared 32x32
// multiplier. in_stall_o is high from the accepting edge until the result has
// moved into the output register. Each iteration runs the escape test and
// then the complex multiplies (1 multiply for the square modes, power-1 for
// multibrot). A request also holds the block while its waiting result is
// stalled.
module fractal_escape_time_iterator (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [31:0]                  c_real_i,
  input  wire  [31:0]                  c_imag_i,
  input  wire  [31:0]                  z0_real_i,
  input  wire  [31:0]                  z0_imag_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [15:0]                  iterations_o,
  output logic [31:0]                  final_real_o,
  output logic [31:0]                  final_imag_o,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [3:0]                   paddr,
  input  wire  [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  localparam int unsigned AccW = feti_pkg::AccBits;

  feti_pkg::state_e state_q, state_d;
  logic [2:0]  ph_q, ph_d;
  logic [2:0]  kc_q, kc_d;
  logic [1:0]  mode_q;
  logic [2:0]  power_q;
  logic [15:0] maxit_q;
  logic [31:0] thr_q;
  logic [15:0] count_q, count_d;
  feti_pkg::word_t cr_q, ci_q, zr_q, zi_q, wr_q, wi_q, tr_q;
  feti_pkg::word_t zr_d, zi_d, wr_d, wi_d, tr_d;
  feti_pkg::acc_t  acc_q, acc_d;
  logic signed [63:0] prod_q;
  feti_pkg::word_t ma, mb, ar, ai, br, bi, ti, nr, ni;
  logic [2:0]  pclamp;
  logic        cfg_wr, in_bound, in_acc, out_load;
  logic [AccW-1:0] thr_ext;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (feti_pkg::reg_e'(paddr[3:2]))
      feti_pkg::REG_MODE:  prdata = {30'd0, mode_q};
      feti_pkg::REG_POWER: prdata = {29'd0, power_q};
      feti_pkg::REG_MAXIT: prdata = {16'd0, maxit_q};
      feti_pkg::REG_THR:   prdata = thr_q;
      default:             prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 2'd0;
      power_q <= 3'd3;
      maxit_q <= 16'd256;
      thr_q   <= 32'd1073741824;
    end else if (cfg_wr) begin
      unique case (feti_pkg::reg_e'(paddr[3:2]))
        feti_pkg::REG_MODE:  mode_q  <= pwdata[1:0];
        feti_pkg::REG_POWER: power_q <= pwdata[2:0];
        feti_pkg::REG_MAXIT: maxit_q <= pwdata[15:0];
        feti_pkg::REG_THR:   thr_q   <= pwdata;
        default: ;
      endcase
    end
  end

  assign pclamp = (power_q < 3'(feti_pkg::PowerMin)) ? 3'(feti_pkg::PowerMin) :
                  (power_q > 3'(feti_pkg::PowerMax)) ? 3'(feti_pkg::PowerMax) : power_q;

  assign in_stall_o = (state_q != feti_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == feti_pkg::S_DONE) && (!out_valid_o || !out_stall_i);

  // multiply operands
  assign ar = wr_q;
  assign ai = wi_q;
  assign br = (feti_pkg::mode_e'(mode_q) == feti_pkg::MODE_MULTI) ? zr_q : wr_q;
  assign bi = (feti_pkg::mode_e'(mode_q) == feti_pkg::MODE_MULTI) ? zi_q : wi_q;

  always_comb begin
    ma = ar;
    mb = br;
    if (state_q == feti_pkg::S_CHK) begin
      ma = (ph_q == 3'd0) ? zr_q : zi_q;
      mb = ma;
    end else begin
      unique case (ph_q)
        3'd1:    begin ma = ai; mb = bi; end
        3'd2:    begin ma = ar; mb = bi; end
        3'd3:    begin ma = ai; mb = br; end
        default: begin ma = ar; mb = br; end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
  end

  assign thr_ext  = AccW'({thr_q, {feti_pkg::FracBits{1'b0}}});
  assign in_bound = $unsigned(acc_q) <= thr_ext;
  assign ti       = feti_pkg::narrow(acc_q);
  assign nr       = feti_pkg::sat_add(tr_q, cr_q);
  assign ni       = feti_pkg::sat_add(ti, ci_q);

  always_comb begin
    state_d = state_q;
    ph_d    = ph_q + 3'd1;
    kc_d    = kc_q;
    count_d = count_q;
    acc_d   = acc_q;
    zr_d    = zr_q;
    zi_d    = zi_q;
    wr_d    = wr_q;
    wi_d    = wi_q;
    tr_d    = tr_q;
    unique case (state_q)
      feti_pkg::S_IDLE: begin
        ph_d = 3'd0;
        if (in_acc) begin
          state_d = feti_pkg::S_CHK;
          zr_d    = z0_real_i;
          zi_d    = z0_imag_i;
          count_d = 16'd0;
        end
      end
      feti_pkg::S_CHK: begin
        if (ph_q == 3'd1) acc_d = AccW'(prod_q);
        if (ph_q == 3'd2) acc_d = acc_q + AccW'(prod_q);
        if (ph_q == 3'd3) begin
          ph_d = 3'd0;
          if (count_q < maxit_q && in_bound) begin
            state_d = feti_pkg::S_MUL;
            kc_d    = pclamp - 3'd1;
            wr_d    = zr_q;
            wi_d    = zi_q;
            if (feti_pkg::mode_e'(mode_q) == feti_pkg::MODE_SHIP) begin
              wr_d = feti_pkg::sat_abs(zr_q);
              wi_d = feti_pkg::sat_abs(zi_q);
            end else if (feti_pkg::mode_e'(mode_q) == feti_pkg::MODE_HYBRID) begin
              wr_d = feti_pkg::sat_abs(zr_q);
            end
          end else begin
            state_d = feti_pkg::S_DONE;
          end
        end
      end
      feti_pkg::S_MUL: begin
        unique case (ph_q)
          3'd1: acc_d = AccW'(prod_q);
          3'd2: acc_d = acc_q - AccW'(prod_q);
          3'd3: begin
            tr_d  = feti_pkg::narrow(acc_q);
            acc_d = AccW'(prod_q);
          end
          3'd4: acc_d = acc_q + AccW'(prod_q);
          3'd5: begin
            ph_d = 3'd0;
            if (feti_pkg::mode_e'(mode_q) == feti_pkg::MODE_MULTI && kc_q > 3'd1) begin
              kc_d = kc_q - 3'd1;
              wr_d = tr_q;
              wi_d = ti;
            end else begin
              zr_d    = nr;
              zi_d    = ni;
              count_d = count_q + 16'd1;
              state_d = feti_pkg::S_CHK;
            end
          end
          default: ;
        endcase
      end
      feti_pkg::S_DONE: begin
        ph_d = 3'd0;
        if (out_load) state_d = feti_pkg::S_IDLE;
      end
      default: state_d = feti_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= feti_pkg::S_IDLE;
      ph_q        <= 3'd0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      if (out_load) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    kc_q    <= kc_d;
    count_q <= count_d;
    acc_q   <= acc_d;
    zr_q    <= zr_d;
    zi_q    <= zi_d;
    wr_q    <= wr_d;
    wi_q    <= wi_d;
    tr_q    <= tr_d;
    if (in_acc) begin
      cr_q <= c_real_i;
      ci_q <= c_imag_i;
    end
    if (out_load) begin
      iterations_o <= count_q;
      final_real_o <= zr_q;
      final_imag_o <= zi_q;
    end
  end

  `FETI_ASSERT(a_accept_starts, in_acc |=> state_q == feti_pkg::S_CHK, "accept did not start")
  `FETI_ASSERT(a_count_limit, state_q != feti_pkg::S_IDLE |-> count_q <= maxit_q, "count over limit")
  `FETI_ASSERT(a_mul_phase, state_q == feti_pkg::S_MUL |-> ph_q <= 3'd5, "bad multiply phase")
  `FETI_ASSERT(a_done_loads, out_load |=> out_valid_o && state_q == feti_pkg::S_IDLE, "result lost")
  `FETI_ASSERT_RST(a_rst_idle, !rst_ni |=> state_q == feti_pkg::S_IDLE, "not idle in reset")
endmodule
`default_nettype wire
